// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker of this project.
// No dependencies; take it in with a plain include of the file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every clock edge, reset cycles included.
`define ASSERT_CLK_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/olae_pkg.sv
// Shared types and constants of the ordered list block.
// No dependencies; the top, the controller, both checkers and the testbench import it.
package olae_pkg;

  localparam int DEF_CAPACITY  = 256;
  localparam int DEF_WORD_BITS = 32;
  localparam int VALUE_W       = 32;
  localparam int IDX_W         = 8;
  localparam int COUNT_W       = 9;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_ERASE  = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } res_t;

endpackage

// File: rtl/ordered_list_append_erase.sv
// Top level of the fixed-capacity ordered list with append, erase, read and clear.
// Depends on olae_pkg, olae_mem and olae_ctrl.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------
//   in      | in_valid / in_stall  | kind, value, index
//   out     | out_valid / out_stall| read_value, count, status
//
// One request is worked on at a time. Append, clear and any rejected request
// finish straight from the idle state; a read first passes the registered memory port.
// An erase makes a single pass over the memory that the scan and the shift share,
// one entry per cycle, bounded by the single read port.
// Reset clears the fill count and the sequencer and output state; entry contents are
// not cleared, since no entry at or beyond the count can be read.
// A stalled result waits in the output register while the next request is
// taken; that request then finishes only once the output register is freed.
module ordered_list_append_erase import olae_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [VALUE_W-1:0] value,
  input  logic [IDX_W-1:0]   index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] read_value,
  output logic [COUNT_W-1:0] count,
  output logic [1:0]         status
);

  localparam int AW = $clog2(CAPACITY);

  logic [WORD_BITS-1:0] value_w;
  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;
  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [WORD_BITS-1:0] mem_rd_data;
  logic                 res_valid;
  logic                 res_take;
  res_t                 res;
  res_t                 out_res;
  logic                 out_valid_next;

  // Only the low WORD_BITS bits of a value take part; wider words are zero-extended.
  assign value_w = WORD_BITS'(value);

  olae_ctrl #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .value_w     (value_w),
    .index       (index),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res)
  );

  olae_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // The output register takes a finished result whenever it is empty or its
  // current result leaves in the same cycle.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_comb begin
    out_valid_next = out_valid;
    if (res_take) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign read_value = out_res.read_value;
  assign count      = out_res.count;
  assign status     = out_res.status;

endmodule

// File: rtl/olae_mem.sv
// Entry store of the ordered list: one write port, one read port, registered read.
// Depends on nothing but its parameters.
module olae_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/olae_ctrl.sv
// Sequencer of the ordered list: fill count, request decode, erase scan and shift.
// Depends on olae_pkg; drives the ports of olae_mem.
module olae_ctrl import olae_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           kind,
  input  logic [WORD_BITS-1:0] value_w,
  input  logic [IDX_W-1:0]     index,
  output logic                 mem_wr_en,
  output logic [AW-1:0]        mem_wr_addr,
  output logic [WORD_BITS-1:0] mem_wr_data,
  output logic                 mem_rd_en,
  output logic [AW-1:0]        mem_rd_addr,
  input  logic [WORD_BITS-1:0] mem_rd_data,
  output logic                 res_valid,
  input  logic                 res_take,
  output res_t                 res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_SEARCH = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t               state, state_next;
  logic [CNT_W-1:0]     fill, fill_next;
  logic [CNT_W-1:0]     ptr, ptr_next;
  logic [AW-1:0]        pend_addr, pend_addr_next;
  logic [WORD_BITS-1:0] key, key_next;
  res_t                 res_next;

  logic [CNT_W-1:0] fill_inc, fill_dec;
  logic             issue;
  logic             in_range;

  assign fill_inc = fill + CNT_W'(1);
  assign fill_dec = fill - CNT_W'(1);
  // A scan read is issued while the pointer is still inside the list.
  assign issue    = (ptr < fill);
  assign in_range = (CMP_W'(index) < CMP_W'(fill));

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    ptr_next       = ptr;
    pend_addr_next = pend_addr;
    key_next       = key;
    res_next       = res;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = AW'(fill);
    mem_wr_data    = value_w;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = AW'(ptr);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_next   = '{read_value: '0, count: COUNT_W'(fill), status: ST_OK};
          state_next = S_DONE;
          unique case (op_t'(kind))
            OP_APPEND: begin
              if (fill < CNT_W'(CAPACITY)) begin
                mem_wr_en      = 1'b1;
                fill_next      = fill_inc;
                res_next.count = COUNT_W'(fill_inc);
              end else begin
                res_next.status = ST_FULL;
              end
            end
            OP_ERASE: begin
              if (fill != '0) begin
                key_next       = value_w;
                mem_rd_en      = 1'b1;
                mem_rd_addr    = '0;
                ptr_next       = CNT_W'(1);
                pend_addr_next = '0;
                state_next     = S_SEARCH;
              end else begin
                res_next.status = ST_NOMATCH;
              end
            end
            OP_READ: begin
              if (in_range) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(index);
                state_next  = S_READ;
              end else begin
                res_next.status = ST_RANGE;
              end
            end
            OP_CLEAR: begin
              fill_next      = '0;
              res_next.count = '0;
            end
          endcase
        end
      end

      S_READ: begin
        res_next.read_value = VALUE_W'(mem_rd_data);
        state_next          = S_DONE;
      end

      S_SEARCH: begin
        // The data on the read port belongs to pend_addr; the next address
        // is already on its way, which lets the shift start without a gap.
        mem_rd_en = issue;
        if (issue) begin
          ptr_next       = ptr + CNT_W'(1);
          pend_addr_next = AW'(ptr);
        end
        if (mem_rd_data == key) begin
          if (!issue) begin
            fill_next      = fill_dec;
            res_next.count = COUNT_W'(fill_dec);
            state_next     = S_DONE;
          end else begin
            state_next = S_SHIFT;
          end
        end else if (!issue) begin
          res_next.status = ST_NOMATCH;
          state_next      = S_DONE;
        end
      end

      S_SHIFT: begin
        // Each entry moves down by one; writes trail reads by two addresses.
        mem_rd_en = issue;
        if (issue) begin
          ptr_next       = ptr + CNT_W'(1);
          pend_addr_next = AW'(ptr);
        end
        mem_wr_en   = 1'b1;
        mem_wr_addr = pend_addr - AW'(1);
        mem_wr_data = mem_rd_data;
        if (!issue) begin
          fill_next      = fill_dec;
          res_next.count = COUNT_W'(fill_dec);
          state_next     = S_DONE;
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    pend_addr <= pend_addr_next;
    key       <= key_next;
    res       <= res_next;
  end

endmodule

// File: rtl/olae_chk.sv
// Port-level checker of the ordered list and the bind that attaches it.
// Depends on olae_pkg and assert_macros.svh.
`include "assert_macros.svh"

module olae_chk import olae_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [VALUE_W-1:0] read_value,
  input logic [COUNT_W-1:0] count,
  input logic [1:0]         status
);

  localparam int CHK_CAP = (CAPACITY > 511) ? 511 : CAPACITY;

  `ASSERT_CLK_ALL(a_no_result_after_reset, clk, rst |=> !out_valid, "result right after reset")
  `ASSERT_CLK(a_count_bound, clk, rst, out_valid |-> count <= COUNT_W'(CHK_CAP), "count too large")
  `ASSERT_CLK(a_full_count, clk, rst, (out_valid && status == ST_FULL) |-> count == COUNT_W'(CAPACITY), "full flag without full list")
  `ASSERT_CLK(a_fail_zero, clk, rst, (out_valid && status != ST_OK) |-> read_value == '0, "failed request returned data")
  `ASSERT_CLK(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(count) && $stable(status)), "stalled result changed")

endmodule

bind ordered_list_append_erase olae_chk #(
  .CAPACITY (CAPACITY)
) u_olae_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_value (read_value),
  .count      (count),
  .status     (status)
);

// File: test/ordered_list_append_erase_check.sv
// Checker for the ordered list block: watches the request and result channels.
// It predicts each result from its own copy of the list and compares it field by field.
// Depends on olae_pkg for the operation and status codes and the result type.
module ordered_list_append_erase_check import olae_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [VALUE_W-1:0] value,
  input  logic [IDX_W-1:0]   index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [VALUE_W-1:0] read_value,
  input  logic [COUNT_W-1:0] count,
  input  logic [1:0]         status,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen
);

  localparam logic [VALUE_W-1:0] WORD_MASK =
    (WORD_BITS >= VALUE_W) ? '1 : ((VALUE_W'(1) << WORD_BITS) - VALUE_W'(1));

  logic [VALUE_W-1:0] list_words [CAPACITY];
  int                 list_len;
  res_t               expected_results [$];
  res_t               want;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    list_len     = 0;
  end

  // Applies one request to the shadow list and returns the result it must produce.
  function automatic res_t list_apply(op_t op, logic [VALUE_W-1:0] key,
                                      logic [IDX_W-1:0] pos);
    res_t r;
    int   hit;
    int   i;
    r.read_value = '0;
    r.status     = ST_OK;
    hit          = -1;
    case (op)
      OP_APPEND: begin
        if (list_len < CAPACITY) begin
          list_words[list_len] = key;
          list_len++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_ERASE: begin
        for (i = 0; i < list_len && hit < 0; i++)
          if (list_words[i] == key) hit = i;
        if (hit < 0) begin
          r.status = ST_NOMATCH;
        end else begin
          for (i = hit; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
      OP_READ: begin
        if (int'(pos) < list_len) r.read_value = list_words[pos];
        else r.status = ST_RANGE;
      end
      default: begin
        list_len = 0;
      end
    endcase
    r.count = COUNT_W'(list_len);
    return r;
  endfunction

  task automatic report(string msg);
    if (fail_count < 10) $display("MISMATCH: %s", msg);
    fail_count++;
  endtask

  // The result is compared before the new request is predicted: a request taken at
  // this edge cannot have its result at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      list_len = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report($sformatf("result with none expected: read_value %h count %0d status %0d",
                           read_value, count, status));
        end else begin
          want = expected_results.pop_front();
          if (want.read_value !== read_value)
            report($sformatf("read_value expected %h got %h", want.read_value, read_value));
          if (want.count !== count)
            report($sformatf("count expected %0d got %0d", want.count, count));
          if (want.status !== status)
            report($sformatf("status expected %0d got %0d", want.status, status));
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(list_apply(op_t'(kind), value & WORD_MASK, index));
    end
    pending <= expected_results.size();
  end

endmodule

// File: test/ordered_list_append_erase_test.sv
// Top of the ordered list testbench: clock, reset, request stimulus and the verdict.
// Depends on olae_pkg, the block ordered_list_append_erase and the checker module.
module ordered_list_append_erase_test;
  import olae_pkg::*;

  // The slowest correct run stays far below this: about 550 requests, each at most
  // a full-list erase plus sender gaps and receiver stalls.
  localparam int CYCLE_LIMIT = 1_000_000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         kind;
  logic [VALUE_W-1:0] value;
  logic [IDX_W-1:0]   index;
  logic               out_valid;
  logic               out_stall;
  logic [VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0] count;
  logic [1:0]         status;

  int fail_count;
  int pending;
  int results_seen;

  // Percent chances that the sender leaves a cycle empty and that the receiver stalls.
  int send_idle_pct;
  int stall_pct;
  int cycles;
  int sent_by_op [4];

  // A small pool of words makes erases hit often and creates duplicates, so that
  // the first-match rule is exercised. Both extremes of the word are in the pool.
  logic [VALUE_W-1:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                          32'h8000_0000, 32'h1234_5678, 32'hA5A5_5A5A,
                                          32'h0000_00FF, 32'h7FFF_FFFE};

  ordered_list_append_erase u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .value      (value),
    .index      (index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .count      (count),
    .status     (status)
  );

  ordered_list_append_erase_check u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .value        (value),
    .index        (index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_value   (read_value),
    .count        (count),
    .status       (status),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver decides afresh every cycle whether to stall the result channel.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 70) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Mostly small positions, where the list usually has entries; sometimes any position.
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 99) < 80) return IDX_W'($urandom_range(0, 15));
    return IDX_W'($urandom_range(0, 255));
  endfunction

  // Offers one request and returns at the edge that accepts it. The sender may
  // first leave a random number of empty cycles. The payload is held while stalled.
  task automatic send(op_t op, logic [VALUE_W-1:0] v, logic [IDX_W-1:0] pos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= op;
    value    <= v;
    index    <= pos;
    sent_by_op[op]++;
    do @(posedge clk); while (in_stall);
  endtask

  // One random request: appends outweigh erases so the list grows,
  // and an occasional clear pulls it back to empty.
  task automatic send_mixed();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) send(OP_APPEND, pick_value(), IDX_W'($urandom));
    else if (roll < 65) send(OP_ERASE, pick_value(), IDX_W'($urandom));
    else if (roll < 95) send(OP_READ, $urandom, pick_index());
    else send(OP_CLEAR, $urandom, IDX_W'($urandom));
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    kind          = OP_APPEND;
    value         = '0;
    index         = '0;
    out_stall     = 1'b0;
    cycles        = 0;
    send_idle_pct = 33;
    stall_pct     = 73;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. It starts on the empty list: a read there is out of range
    // and an erase finds no match.
    send(OP_READ, 32'h0, 8'd0);
    send(OP_ERASE, 32'h0, 8'd0);
    // Both extremes of the word, with a duplicate to test that erase takes the first.
    send(OP_APPEND, 32'h0000_0000, 8'd0);
    send(OP_APPEND, 32'hFFFF_FFFF, 8'd0);
    send(OP_APPEND, 32'hA5A5_5A5A, 8'd0);
    send(OP_APPEND, 32'hFFFF_FFFF, 8'd0);
    send(OP_APPEND, 32'h5A5A_A5A5, 8'd0);
    send(OP_READ, 32'h0, 8'd0);
    send(OP_READ, 32'h0, 8'd1);
    send(OP_READ, 32'h0, 8'd4);
    // Reads at the count itself and at the top position are out of range.
    send(OP_READ, 32'h0, 8'd5);
    send(OP_READ, 32'hFFFF_FFFF, 8'd255);
    // Erasing the duplicate removes position 1; the later copy moves down to 2.
    send(OP_ERASE, 32'hFFFF_FFFF, 8'd0);
    send(OP_READ, 32'h0, 8'd1);
    send(OP_READ, 32'h0, 8'd2);
    send(OP_ERASE, 32'h1234_5678, 8'd0);
    // Erase of the last entry, then of the first.
    send(OP_ERASE, 32'h5A5A_A5A5, 8'd0);
    send(OP_ERASE, 32'h0000_0000, 8'd0);
    send(OP_READ, 32'h0, 8'd0);
    // After a clear the old contents are still in memory but must not be found.
    send(OP_CLEAR, 32'h0, 8'd0);
    send(OP_READ, 32'h0, 8'd0);
    send(OP_ERASE, 32'hA5A5_5A5A, 8'd0);
    send(OP_APPEND, 32'h0000_0007, 8'd0);
    send(OP_READ, 32'h0, 8'd0);

    // Random part, first with a slow sender and a busy receiver.
    repeat (120) send_mixed();

    // Then the other way round, with a run that fills the list completely. Appends
    // past the capacity must be dropped, and reads reach every index bit.
    send_idle_pct = 73;
    stall_pct     = 33;
    send(OP_CLEAR, $urandom, IDX_W'($urandom));
    repeat (DEF_CAPACITY) send(OP_APPEND, pick_value(), IDX_W'($urandom));
    repeat (4) send(OP_APPEND, $urandom, IDX_W'($urandom));
    send(OP_READ, $urandom, 8'd255);
    send(OP_READ, $urandom, 8'd0);
    send(OP_READ, $urandom, 8'd128);
    send(OP_ERASE, value_pool[$urandom_range(0, 7)], IDX_W'($urandom));
    send(OP_APPEND, $urandom, IDX_W'($urandom));
    send(OP_APPEND, $urandom, IDX_W'($urandom));
    repeat (16) begin
      if ($urandom_range(0, 1) == 0) send(OP_READ, $urandom, IDX_W'($urandom));
      else send_mixed();
    end

    // Last, both sides run flat out.
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (120) send_mixed();
    in_valid <= 1'b0;

    // The wait below lets the checker record the last request before its queue is polled.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DEF_CAPACITY + 8) @(posedge clk);

    $display("Covered %0d requests: %0d appends, %0d erases, %0d reads, %0d clears.",
             sent_by_op[OP_APPEND] + sent_by_op[OP_ERASE] + sent_by_op[OP_READ]
               + sent_by_op[OP_CLEAR],
             sent_by_op[OP_APPEND], sent_by_op[OP_ERASE], sent_by_op[OP_READ],
             sent_by_op[OP_CLEAR]);
    $display("Checked %0d results under three stall mixes, including a full list; %0d failures.",
             results_seen, fail_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: ordered_list_append_erase.f
+incdir+rtl
rtl/olae_pkg.sv
rtl/olae_mem.sv
rtl/olae_ctrl.sv
rtl/ordered_list_append_erase.sv
rtl/olae_chk.sv
test/ordered_list_append_erase_check.sv
test/ordered_list_append_erase_test.sv
